/* hw/rtl/spq_pkg.sv */
// Shared constants, cell control codes and types for the sorted priority queue.
package spq_pkg;

    // Field widths
    localparam int VAL_W        = 32;
    localparam int CNT_OUT_W    = 5;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 40;
    localparam int CAPACITY_DEF = 16;

    // Operation broadcast to every cell
    typedef logic [1:0] op_t;
    localparam op_t OP_HOLD   = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_POP    = 2'd2;
    localparam op_t OP_SORT   = 2'd3;

    // Input command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // Control bundle from the sequencer to the cell row
    typedef struct packed {
        op_t                     op;
        logic                    mode;   // 0: smallest at head, 1: largest at head
        logic                    phase;  // odd/even pair select for a sort step
        logic signed [VAL_W-1:0] value;  // value being inserted
    } spq_ctl_t;

endpackage

/* hw/rtl/spq_cell.sv */
// One storage cell of the sorted row: holds one entry and trades with its neighbors.
module spq_cell
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int INDEX    = 0,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                    clk,
    input  spq_ctl_t                ctl,
    input  logic [CNT_W-1:0]        count,
    input  logic signed [VAL_W-1:0] left_value,
    input  logic                    left_behind,
    input  logic                    left_swap,
    input  logic signed [VAL_W-1:0] right_value,
    output logic signed [VAL_W-1:0] entry,
    output logic                    behind,
    output logic                    swap
);

    localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX1 = CNT_W'(INDEX + 1);
    localparam logic             PAR  = 1'(INDEX % 2);

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;
    logic                    live;
    logic                    take_new;

    // a must stand strictly behind b under the given mode
    function automatic logic stands_behind(input logic mode,
                                           input logic signed [VAL_W-1:0] a,
                                           input logic signed [VAL_W-1:0] b);
        stands_behind = mode ? (a < b) : (a > b);
    endfunction

    // Insert: this entry moves back if the new value goes ahead of it
    assign live     = (IDX < count);
    assign behind   = live && stands_behind(ctl.mode, entry_reg, ctl.value);
    assign take_new = !left_behind && (behind || (IDX == count));

    // Sort step: this cell is the left side of a live pair that is out of order
    assign swap = (ctl.phase == PAR) && (IDX1 < count)
                  && stands_behind(ctl.mode, entry_reg, right_value);

    // Next entry
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.op)
            OP_INSERT:
            begin
                if (take_new)
                begin
                    entry_next = ctl.value;
                end
                else if (left_behind)
                begin
                    entry_next = left_value;
                end
            end
            OP_POP:
            begin
                entry_next = right_value;
            end
            OP_SORT:
            begin
                if (swap)
                begin
                    entry_next = right_value;
                end
                else if (left_swap)
                begin
                    entry_next = left_value;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Entry storage (payload, no reset)
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* hw/rtl/spq_ctrl.sv */
// Sequencer: handshakes, entry count, order mode, re-sort steps and result register.
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    in_cmd,
    input  logic signed [VAL_W-1:0] in_value,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic signed [VAL_W-1:0] head_value,
    output logic                    empty_error,
    output logic                    full_error,
    output logic [CNT_OUT_W-1:0]    count_out,
    input  logic                    cfg_wr_en,
    input  logic                    cfg_wr_data,
    input  logic signed [VAL_W-1:0] head_entry,
    output spq_ctl_t                ctl,
    output logic [CNT_W-1:0]        count
);

    localparam int PH_W = $clog2(CAPACITY);
    localparam logic [PH_W-1:0]  PH_LAST = PH_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_INS  = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [PH_W-1:0]         phase_reg, phase_next;
    logic                    order_mode_reg;
    logic                    sorted_mode_reg, sorted_mode_next;
    logic signed [VAL_W-1:0] pend_reg, pend_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic signed [VAL_W-1:0] head_reg, head_next;
    logic                    empty_reg, empty_next;
    logic                    full_reg, full_next;
    logic [CNT_OUT_W-1:0]    cnt_out_reg, cnt_out_next;
    logic                    out_free;
    logic                    accept;
    logic                    produce;
    op_t                     op;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        phase_next       = phase_reg;
        sorted_mode_next = sorted_mode_reg;
        pend_next        = pend_reg;
        op               = OP_HOLD;
        produce          = 1'b0;
        head_next        = '0;
        empty_next       = 1'b0;
        full_next        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == CMD_POP)
                    begin
                        produce = 1'b1;
                        if (cnt_reg == '0)
                        begin
                            empty_next = 1'b1;
                        end
                        else
                        begin
                            op        = OP_POP;
                            head_next = head_entry;
                            cnt_next  = cnt_reg - CNT_ONE;
                        end
                    end
                    else if (cnt_reg == CNT_MAX)
                    begin
                        produce   = 1'b1;
                        full_next = 1'b1;
                    end
                    else if ((order_mode_reg != sorted_mode_reg) && (cnt_reg > CNT_ONE))
                    begin
                        // store is ordered the other way: re-sort before inserting
                        pend_next  = in_value;
                        phase_next = '0;
                        state_next = ST_SORT;
                    end
                    else
                    begin
                        produce          = 1'b1;
                        op               = OP_INSERT;
                        cnt_next         = cnt_reg + CNT_ONE;
                        sorted_mode_next = order_mode_reg;
                    end
                end
            end
            ST_SORT:
            begin
                op         = OP_SORT;
                phase_next = phase_reg + PH_W'(1);
                if (phase_reg == PH_LAST)
                begin
                    sorted_mode_next = order_mode_reg;
                    state_next       = ST_INS;
                end
            end
            ST_INS:
            begin
                if (out_free)
                begin
                    produce    = 1'b1;
                    op         = OP_INSERT;
                    cnt_next   = cnt_reg + CNT_ONE;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        m_tvalid_next = produce || (m_tvalid_reg && !m_tready);
        cnt_out_next  = CNT_OUT_W'(cnt_next);
    end

    // Broadcast to the cell row
    assign ctl.op    = op;
    assign ctl.mode  = order_mode_reg;
    assign ctl.phase = phase_reg[0];
    assign ctl.value = (state_reg == ST_INS) ? pend_reg : in_value;
    assign count     = cnt_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            phase_reg       <= '0;
            order_mode_reg  <= 1'b0;
            sorted_mode_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            phase_reg       <= phase_next;
            sorted_mode_reg <= sorted_mode_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                order_mode_reg <= cfg_wr_data;
            end
        end
    end

    // Pending value and result payload
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (produce)
        begin
            head_reg    <= head_next;
            empty_reg   <= empty_next;
            full_reg    <= full_next;
            cnt_out_reg <= cnt_out_next;
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign head_value  = head_reg;
    assign empty_error = empty_reg;
    assign full_error  = full_reg;
    assign count_out   = cnt_out_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("entry count above capacity");

    a_sort_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT && phase_reg != PH_LAST) |=> (state_reg == ST_SORT))
        else $error("sort pass cut short");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_cmd == CMD_POP && cnt_reg == '0)
        |=> (m_tvalid && empty_error && cnt_reg == '0))
        else $error("pop on empty queue not flagged");

    a_ins_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS && out_free)
        |=> (state_reg == ST_IDLE && m_tvalid && cnt_reg == $past(cnt_reg) + CNT_ONE))
        else $error("deferred insert lost");
`endif

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// Top level of the sorted priority queue: sequencer plus a row of storage cells.
//
//  port group  dir   width  contents (low bit first)
//  s_*         in    32+1   tdata: value[31:0]; tuser: cmd
//  m_*         out   40     head_value[31:0], empty_error[32], full_error[33], count[38:34]
//  cfg_*       in    1      order_mode write
//
// Pops, plain inserts and refused items are answered straight from idle; the result is registered
// and a new item is taken in the same cycle the waiting result leaves.
// An insert after an order mode change with two or more entries held first runs CAPACITY
// odd/even swap steps, then is made from ST_INS once the result output is free.
// Reset clears the count and the mode; entry contents need no clearing.
// A stalled result blocks new items only while m_tvalid is high and m_tready low.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // value
    input  logic                 s_tuser,   // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // head_value, empty_error, full_error, count, pad
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                    in_cmd;
    logic signed [VAL_W-1:0] in_value;
    logic signed [VAL_W-1:0] head_value;
    logic                    empty_error;
    logic                    full_error;
    logic [CNT_OUT_W-1:0]    count_out;
    spq_ctl_t                ctl;
    logic [CNT_W-1:0]        count;

    logic signed [VAL_W-1:0] entry  [CAPACITY];
    logic                    behind [CAPACITY];
    logic                    swap   [CAPACITY];

    // Unpack input item
    assign in_cmd   = s_tuser;
    assign in_value = s_tdata;

    // Pack result item
    assign m_tdata = {{(M_TDATA_W - VAL_W - 2 - CNT_OUT_W){1'b0}},
                      count_out, full_error, empty_error, head_value};

    spq_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_cmd      (in_cmd),
        .in_value    (in_value),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .head_value  (head_value),
        .empty_error (empty_error),
        .full_error  (full_error),
        .count_out   (count_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_entry  (entry[0]),
        .ctl         (ctl),
        .count       (count)
    );

    // Cell row: entry 0 is the head
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] lv;
        logic                    lb;
        logic                    ls;
        logic signed [VAL_W-1:0] rv;

        if (i == 0)
        begin : g_first
            assign lv = '0;
            assign lb = 1'b0;
            assign ls = 1'b0;
        end
        else
        begin : g_mid
            assign lv = entry[i-1];
            assign lb = behind[i-1];
            assign ls = swap[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rv = '0;
        end
        else
        begin : g_inner
            assign rv = entry[i+1];
        end

        spq_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .count       (count),
            .left_value  (lv),
            .left_behind (lb),
            .left_swap   (ls),
            .right_value (rv),
            .entry       (entry[i]),
            .behind      (behind[i]),
            .swap        (swap[i])
        );
    end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the sorted priority queue: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
    import spq_pkg::*;

    localparam int DEPTH      = CAPACITY_DEF;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 80;
    localparam int LONG_HOLD  = 60;
    localparam int DRAIN_WAIT = DEPTH + 4;
    localparam int DIR_ROWS   = 24;

    // One result item as the block reports it
    typedef struct packed {
        logic signed [VAL_W-1:0] head;
        logic                    empty_err;
        logic                    full_err;
        logic [CNT_OUT_W-1:0]    count;
    } pop_result_t;

    // One row of the directed stimulus table
    typedef struct packed {
        logic                    cmd;
        logic signed [VAL_W-1:0] value;
        logic                    typed;
        pop_result_t             result;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en;
    logic                 cfg_wr_data;

    // Typed expectation travels alongside the item it belongs to
    logic                 row_typed;
    pop_result_t          row_result;

    // Shadow copy of the queue
    logic signed [VAL_W-1:0] shadow_store [0:DEPTH-1];
    int                      shadow_count;
    logic                    shadow_order;

    pop_result_t expected_results [$];
    pop_result_t got;
    pop_result_t want;
    dir_row_t    dir_table [0:DIR_ROWS-1];

    int  errors;
    int  n_insert;
    int  n_pop;
    int  n_empty;
    int  n_full;
    int  n_cfg;
    bit  tx_idle_en;
    bit  rx_idle_en;
    bit  rx_hold_req;
    int  hold_cycles;

    sorted_priority_queue #(
        .CAPACITY (DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // value
        .s_tuser     (s_tuser),     // cmd
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // head_value, empty_error, full_error, count, pad
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one item to the shadow queue and return the result it should give
    function automatic pop_result_t apply_item(input logic cmd,
                                               input logic signed [VAL_W-1:0] val);
        pop_result_t             r;
        int                      i;
        int                      k;
        logic signed [VAL_W-1:0] v;
        r = '0;
        if (cmd == CMD_INSERT)
        begin
            if (shadow_count >= DEPTH)
                r.full_err = 1'b1;
            else
            begin
                shadow_store[shadow_count] = val;
                shadow_count++;
                // full re-sort under the current order, so a mode change takes effect here
                for (i = 1; i < shadow_count; i++)
                begin
                    v = shadow_store[i];
                    k = i;
                    while (k > 0 && (shadow_order ? (shadow_store[k-1] < v)
                                                  : (shadow_store[k-1] > v)))
                    begin
                        shadow_store[k] = shadow_store[k-1];
                        k--;
                    end
                    shadow_store[k] = v;
                end
            end
        end
        else if (shadow_count == 0)
            r.empty_err = 1'b1;
        else
        begin
            r.head = shadow_store[0];
            for (i = 1; i < shadow_count; i++)
                shadow_store[i-1] = shadow_store[i];
            shadow_count--;
        end
        r.count = shadow_count[CNT_OUT_W-1:0];
        return r;
    endfunction

    // Monitor: predict on accepted inputs, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                shadow_order = cfg_wr_data;
                n_cfg++;
            end
            if (s_tvalid && s_tready)
            begin
                want = apply_item(s_tuser, s_tdata);
                if (row_typed)
                    want = row_result;
                expected_results.push_back(want);
                if (s_tuser == CMD_INSERT)
                    n_insert++;
                else
                    n_pop++;
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[31:0], m_tdata[32], m_tdata[33], m_tdata[38:34]};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result item expected none actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.head !== want.head)
                    begin
                        $display("%0t: head_value expected %0d actual %0d",
                                 $time, want.head, got.head);
                        errors++;
                    end
                    if (got.empty_err !== want.empty_err)
                    begin
                        $display("%0t: empty_error expected %b actual %b",
                                 $time, want.empty_err, got.empty_err);
                        errors++;
                    end
                    if (got.full_err !== want.full_err)
                    begin
                        $display("%0t: full_error expected %b actual %b",
                                 $time, want.full_err, got.full_err);
                        errors++;
                    end
                    if (got.count !== want.count)
                    begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, got.count);
                        errors++;
                    end
                    if (got.empty_err)
                        n_empty++;
                    if (got.full_err)
                        n_full++;
                end
            end
        end
    end

    // Result side: random back-pressure bursts, plus one long hold on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < LONG_HOLD)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                rx_hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 6) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_item(input logic cmd, input logic signed [VAL_W-1:0] val,
                             input logic typed, input pop_result_t res);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= val;
        s_tuser    <= cmd;
        row_typed  <= typed;
        row_result <= res;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_queue();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Order mode write, only with the block idle
    task automatic set_order(input logic mode);
        drain_queue();
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Watchdog
    initial
    begin
        #1000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus
    initial
    begin
        logic                    cmd;
        logic signed [VAL_W-1:0] val;
        logic                    mode;
        int                      ins_pct;
        int                      sel;
        int                      p;
        int                      n;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        row_typed    = 1'b0;
        row_result   = '0;
        shadow_count = 0;
        shadow_order = 1'b0;
        errors       = 0;
        n_insert     = 0;
        n_pop        = 0;
        n_empty      = 0;
        n_full       = 0;
        n_cfg        = 0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        rx_hold_req  = 1'b0;
        for (n = 0; n < DEPTH; n++)
            shadow_store[n] = '0;

        // pop on empty, fill to the brim with extremes and duplicates, overflow, drain a bit
        dir_table[0]  = '{CMD_POP,    32'sh0,        1'b1, '{32'sh0, 1'b1, 1'b0, 5'd0}};
        dir_table[1]  = '{CMD_INSERT, 32'sh7FFFFFFF, 1'b0, '0};
        dir_table[2]  = '{CMD_INSERT, 32'sh80000000, 1'b0, '0};
        dir_table[3]  = '{CMD_INSERT, 32'sh0,        1'b0, '0};
        dir_table[4]  = '{CMD_INSERT, 32'shFFFFFFFF, 1'b0, '0};
        dir_table[5]  = '{CMD_INSERT, 32'sh1,        1'b0, '0};
        dir_table[6]  = '{CMD_INSERT, 32'sh7FFFFFFF, 1'b0, '0};
        dir_table[7]  = '{CMD_INSERT, 32'sh80000000, 1'b0, '0};
        dir_table[8]  = '{CMD_INSERT, 32'sh5,        1'b0, '0};
        dir_table[9]  = '{CMD_INSERT, -32'sh5,       1'b0, '0};
        dir_table[10] = '{CMD_INSERT, 32'sh55555555, 1'b0, '0};
        dir_table[11] = '{CMD_INSERT, 32'shAAAAAAAA, 1'b0, '0};
        dir_table[12] = '{CMD_INSERT, 32'sd100,      1'b0, '0};
        dir_table[13] = '{CMD_INSERT, -32'sd100,     1'b0, '0};
        dir_table[14] = '{CMD_INSERT, 32'sh40000000, 1'b0, '0};
        dir_table[15] = '{CMD_INSERT, 32'shC0000000, 1'b0, '0};
        dir_table[16] = '{CMD_INSERT, 32'sd7,        1'b0, '0};
        dir_table[17] = '{CMD_INSERT, 32'sd123,      1'b1, '{32'sh0, 1'b0, 1'b1, 5'd16}};
        dir_table[18] = '{CMD_POP,    32'shFFFFFFFF, 1'b1, '{32'sh80000000, 1'b0, 1'b0, 5'd15}};
        dir_table[19] = '{CMD_POP,    32'sh0,        1'b0, '0};
        dir_table[20] = '{CMD_POP,    32'sh0,        1'b0, '0};
        dir_table[21] = '{CMD_POP,    32'sh0,        1'b0, '0};
        dir_table[22] = '{CMD_INSERT, 32'sh7FFFFFFE, 1'b0, '0};
        dir_table[23] = '{CMD_POP,    32'sh0,        1'b0, '0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_order(1'b0);
        for (n = 0; n < DIR_ROWS; n++)
            send_item(dir_table[n].cmd, dir_table[n].value, dir_table[n].typed,
                      dir_table[n].result);

        // random phases; the queue is left partly full across mode changes
        for (p = 0; p < PHASES; p++)
        begin
            mode = (p == 0) ? 1'b1 : (p == PHASES - 1) ? 1'b0 : logic'($urandom_range(0, 1));
            set_order(mode);
            ins_pct = $urandom_range(30, 75);
            if (p == PHASES - 1)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            if (p == 2)
                rx_hold_req = 1'b1;
            for (n = 0; n < PHASE_LEN; n++)
            begin
                if (p == 4 && n == PHASE_LEN / 2)
                    drain_queue();
                cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_POP;
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    val = $urandom;
                else if (sel < 8)
                    val = $signed($urandom_range(0, 15)) - 8;
                else
                    case ($urandom_range(0, 3))
                        0:       val = 32'sh7FFFFFFF;
                        1:       val = 32'sh80000000;
                        2:       val = 32'sh0;
                        default: val = 32'shFFFFFFFF;
                    endcase
                send_item(cmd, val, 1'b0, '0);
            end
        end

        drain_queue();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d inserts and %0d pops, %0d empty pops, %0d dropped inserts,",
                 n_insert, n_pop, n_empty, n_full);
        $display("over %0d order mode writes with back-pressure and a long result stall.",
                 n_cfg);
        if (errors == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
